// ----- rtl/rbsd_pkg.sv -----
package rbsd_pkg;

  localparam int unsigned OUT_BYTES_DEF = 4;
  localparam logic [31:0] MAX_SIZE_RESET = 32'h1000_0000;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_HDR_SHORT = 3'd1;
  localparam logic [2:0] ST_EXT_SHORT = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;
  localparam logic [2:0] ST_LIT_TRUNC = 3'd5;

  typedef struct packed {
    logic       hdr_load;
    logic       rem_load;
    logic       flag_load;
    logic       value_start;
    logic       lit_step;
    logic       fill_step;
    logic       out_lit;
    logic       out_fill;
    logic       out_close;
    logic       stat_load;
    logic [2:0] stat_code;
    logic       clear;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] hdr_idx;
    logic       size_zero;
    logic       size_over;
    logic       run_covers;
    logic       rem_nonzero;
    logic       rem_le1;
    logic       lit_last;
    logic       fill_last;
    logic       out_free;
  } dp_status_t;

endpackage

// ----- rtl/rbsd_ctrl.sv -----
module rbsd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_last_i,
  input  logic                   in_rep_i,
  output logic                   in_stall_o,
  input  rbsd_pkg::dp_status_t   sts_i,
  output rbsd_pkg::dp_cmd_t      cmd_o
);
  import rbsd_pkg::*;

  localparam logic [2:0] P_HEADER  = 3'd0;
  localparam logic [2:0] P_FLAG    = 3'd1;
  localparam logic [2:0] P_VALUE   = 3'd2;
  localparam logic [2:0] P_LITERAL = 3'd3;
  localparam logic [2:0] P_DONE    = 3'd4;
  localparam logic [2:0] P_ERROR   = 3'd5;
  localparam logic [2:0] S_FILL    = 3'd6;
  localparam logic [2:0] S_CLOSE   = 3'd7;

  logic [2:0] state_q, state_d;
  logic [2:0] ret_q, ret_d;
  logic       last_q, last_d;
  logic [2:0] nph;
  logic       is_phase;
  logic       acc;
  logic       hdr_end;

  assign is_phase   = (state_q <= P_ERROR);
  assign in_stall_o = !(is_phase && sts_i.out_free);
  assign acc        = in_valid_i && !in_stall_o;
  assign hdr_end    = ((sts_i.hdr_idx == 3'd3) && !sts_i.size_zero) ||
                      (sts_i.hdr_idx == 3'd7);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    ret_d   = ret_q;
    last_d  = last_q;
    nph     = state_q;
    unique case (state_q)
      P_HEADER: begin
        cmd_o.hdr_load = acc;
        if (hdr_end) begin
          if (sts_i.size_zero) begin
            nph = P_DONE;
          end else if (sts_i.size_over) begin
            nph = P_ERROR;
          end else begin
            nph = P_FLAG;
            cmd_o.rem_load = acc;
          end
        end else begin
          nph = P_HEADER;
        end
      end
      P_FLAG: begin
        cmd_o.flag_load = acc;
        nph = in_rep_i ? P_VALUE : P_LITERAL;
      end
      P_VALUE: begin
        cmd_o.value_start = acc;
        nph = sts_i.run_covers ? P_DONE : P_FLAG;
      end
      P_LITERAL: begin
        cmd_o.lit_step = acc;
        cmd_o.out_lit  = acc && sts_i.rem_nonzero;
        if (sts_i.lit_last) begin
          nph = sts_i.rem_le1 ? P_DONE : P_FLAG;
        end else begin
          nph = P_LITERAL;
        end
      end
      P_DONE, P_ERROR: begin
        nph = state_q;
      end
      S_FILL: begin
        if (sts_i.out_free) begin
          cmd_o.out_fill  = 1'b1;
          cmd_o.fill_step = 1'b1;
          if (sts_i.fill_last) begin
            state_d = last_q ? S_CLOSE : ret_q;
          end
        end
      end
      S_CLOSE: begin
        if (sts_i.out_free) begin
          cmd_o.out_close = 1'b1;
          cmd_o.clear     = 1'b1;
          state_d         = P_HEADER;
        end
      end
      default: begin
        state_d = P_HEADER;
      end
    endcase

    unique case (nph)
      P_HEADER:         cmd_o.stat_code = (sts_i.hdr_idx >= 3'd3) ? ST_EXT_SHORT
                                                                  : ST_HDR_SHORT;
      P_FLAG, P_VALUE:  cmd_o.stat_code = ST_TRUNC;
      P_LITERAL:        cmd_o.stat_code = ST_LIT_TRUNC;
      P_ERROR:          cmd_o.stat_code = ST_TOO_LARGE;
      default:          cmd_o.stat_code = ST_OK;
    endcase

    if (acc) begin
      cmd_o.stat_load = in_last_i;
      if (state_q == P_VALUE) begin
        state_d = S_FILL;
        ret_d   = nph;
        last_d  = in_last_i;
      end else if (in_last_i) begin
        state_d = S_CLOSE;
      end else begin
        state_d = nph;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_HEADER;
      ret_q   <= P_HEADER;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      last_q  <= last_d;
    end
  end

endmodule

// ----- rtl/rbsd_datapath.sv -----
module rbsd_datapath #(
  parameter int unsigned OutBytes = rbsd_pkg::OUT_BYTES_DEF,
  localparam int unsigned DataW   = 8 * OutBytes,
  localparam int unsigned CountW  = $clog2(OutBytes + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [31:0]            cfg_data_i,
  input  logic [7:0]             in_byte_i,
  input  rbsd_pkg::dp_cmd_t      cmd_i,
  output rbsd_pkg::dp_status_t   sts_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [DataW-1:0]       out_data_o,
  output logic [CountW-1:0]      out_count_o,
  output logic                   out_end_o,
  output logic [2:0]             out_status_o
);
  import rbsd_pkg::*;

  logic [31:0]       max_q;
  logic [2:0]        idx_q;
  logic [31:0]       target_q;
  logic [31:0]       rem_q;
  logic [7:0]        lit_q;
  logic [7:0]        run_q;
  logic [7:0]        fill_q;
  logic [7:0]        value_q;
  logic [2:0]        stat_q;
  logic              out_valid_q;
  logic [DataW-1:0]  out_data_q;
  logic [CountW-1:0] out_count_q;
  logic              out_end_q;
  logic [2:0]        out_status_q;

  logic [1:0]        lane;
  logic [31:0]       target_next;
  logic [7:0]        run_n;
  logic [CountW-1:0] fill_take;
  logic [DataW-1:0]  fill_word;
  logic              out_free;
  logic              out_load;

  always_comb begin
    lane = (idx_q <= 3'd3) ? 2'(idx_q - 3'd1) : idx_q[1:0];
    target_next = target_q;
    if (idx_q != 3'd0) begin
      target_next = target_q | ({24'd0, in_byte_i} << {lane, 3'b000});
    end
  end

  assign run_n     = sts_o.run_covers ? rem_q[7:0] : run_q;
  assign fill_take = (fill_q >= 8'(OutBytes)) ? CountW'(OutBytes) : fill_q[CountW-1:0];

  always_comb begin
    for (int i = 0; i < OutBytes; i++) begin
      fill_word[8*i +: 8] = (CountW'(i) < fill_take) ? value_q : 8'd0;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = cmd_i.out_lit || cmd_i.out_fill || cmd_i.out_close;

  assign sts_o.hdr_idx     = idx_q;
  assign sts_o.size_zero   = (target_next == 32'd0);
  assign sts_o.size_over   = (target_next > max_q);
  assign sts_o.run_covers  = ({24'd0, run_q} >= rem_q);
  assign sts_o.rem_nonzero = (rem_q != 32'd0);
  assign sts_o.rem_le1     = (rem_q <= 32'd1);
  assign sts_o.lit_last    = (lit_q == 8'd1);
  assign sts_o.fill_last   = (fill_q <= 8'(OutBytes));
  assign sts_o.out_free    = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_SIZE_RESET;
    end else if (cfg_valid_i) begin
      max_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 3'd0;
      target_q <= 32'd0;
      rem_q    <= 32'd0;
      lit_q    <= 8'd0;
      run_q    <= 8'd0;
      fill_q   <= 8'd0;
    end else if (cmd_i.clear) begin
      idx_q    <= 3'd0;
      target_q <= 32'd0;
      rem_q    <= 32'd0;
      lit_q    <= 8'd0;
      run_q    <= 8'd0;
      fill_q   <= 8'd0;
    end else begin
      if (cmd_i.hdr_load) begin
        target_q <= target_next;
        idx_q    <= ((idx_q == 3'd3) && sts_o.size_zero) ? 3'd4 : idx_q + 3'd1;
      end
      if (cmd_i.rem_load) begin
        rem_q <= target_next;
      end
      if (cmd_i.flag_load) begin
        if (in_byte_i[7]) begin
          run_q <= {1'b0, in_byte_i[6:0]} + 8'd3;
        end else begin
          lit_q <= in_byte_i + 8'd1;
        end
      end
      if (cmd_i.value_start) begin
        fill_q <= run_n;
        rem_q  <= rem_q - {24'd0, run_n};
        run_q  <= 8'd0;
      end
      if (cmd_i.lit_step) begin
        if (sts_o.rem_nonzero) begin
          rem_q <= rem_q - 32'd1;
        end
        lit_q <= lit_q - 8'd1;
      end
      if (cmd_i.fill_step) begin
        fill_q <= fill_q - 8'(fill_take);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.value_start) begin
      value_q <= in_byte_i;
    end
    if (cmd_i.stat_load) begin
      stat_q <= cmd_i.stat_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_lit) begin
      out_data_q   <= DataW'(in_byte_i);
      out_count_q  <= CountW'(1);
      out_end_q    <= 1'b0;
      out_status_q <= ST_OK;
    end else if (cmd_i.out_fill) begin
      out_data_q   <= fill_word;
      out_count_q  <= fill_take;
      out_end_q    <= 1'b0;
      out_status_q <= ST_OK;
    end else if (cmd_i.out_close) begin
      out_data_q   <= '0;
      out_count_q  <= '0;
      out_end_q    <= 1'b1;
      out_status_q <= stat_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_count_o  = out_count_q;
  assign out_end_o    = out_end_q;
  assign out_status_o = out_status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("A result was loaded over one that had not been taken.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill_step |-> (fill_q != 8'd0))
    else $error("A repeat word was emitted with no bytes left in the run.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_fill |=> (out_count_o != '0) && (out_count_o <= CountW'(OutBytes)))
    else $error("A repeat word carries an invalid byte count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lit_step |-> (lit_q != 8'd0))
    else $error("A literal byte was taken with no literal run open.");

endmodule

// ----- rtl/rle_byte_stream_decompressor.sv -----
// Run-length decompressor for a byte stream with a 4- or 8-byte size header.
// Compressed bytes enter on the input channel (in_valid_i / in_stall_o), one
// byte per transaction, with in_last_i marking the final byte of a stream.
// Decompressed bytes leave on the output channel (out_valid_o / out_stall_i),
// up to OutBytes bytes per transaction with the first byte in the low bits.
// The last byte of a stream is followed by one closing transaction with
// out_end_o set, a zero count and the stream status in out_status_o.
// Header, flag and literal bytes are taken back to back while the output
// register is free; a literal byte's result is registered and shows in the
// cycle after it is accepted. A repeat value byte stalls the input while the
// datapath's fill counter emits up to ceil(130/OutBytes) packed words; the
// closing transaction follows the last byte. The output register frees itself
// when its transaction completes, and the input is stalled while it holds an
// untaken result or a repeat or closing result is pending. The size limit is
// written through cfg_valid_i / cfg_data_i by the user only while idle; the
// block does not enforce it. Reset clears the stream state, empties the output
// register and sets the size limit to 0x10000000.
module rle_byte_stream_decompressor #(
  parameter int unsigned OutBytes = rbsd_pkg::OUT_BYTES_DEF,
  localparam int unsigned DataW   = 8 * OutBytes,
  localparam int unsigned CountW  = $clog2(OutBytes + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [31:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DataW-1:0]  out_data_o,
  output logic [CountW-1:0] out_count_o,
  output logic              out_end_o,
  output logic [2:0]        out_status_o
);
  import rbsd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  assign cfg_ready_o = 1'b1;

  rbsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_last_i),
    .in_rep_i   (in_byte_i[7]),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rbsd_datapath #(
    .OutBytes (OutBytes)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_byte_i    (in_byte_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .out_count_o  (out_count_o),
    .out_end_o    (out_end_o),
    .out_status_o (out_status_o)
  );

endmodule

// ----- bench/rbsd_stream_checker.sv -----
`timescale 1ns / 100ps

module rbsd_stream_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [31:0]                          cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic [7:0]                           in_byte_i,
  input  logic                                 in_last_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic [8*rbsd_pkg::OUT_BYTES_DEF-1:0] out_data_i,
  input  logic [2:0]                           out_count_i,
  input  logic                                 out_end_i,
  input  logic [2:0]                           out_status_i,
  output int unsigned                          error_count_o,
  output int unsigned                          pending_o
);
  import rbsd_pkg::*;

  localparam int unsigned OUT_BYTES = OUT_BYTES_DEF;
  localparam int unsigned DATA_W    = 8 * OUT_BYTES;
  localparam int unsigned COUNT_W   = $clog2(OUT_BYTES + 1);
  localparam int unsigned MAX_SHOWN = 10;

  typedef enum logic [2:0] {
    S_HEADER,
    S_FLAG,
    S_VALUE,
    S_LITERAL,
    S_DONE,
    S_FAULT
  } stream_phase_e;

  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    logic               closing;
    logic [2:0]         status;
  } out_word_t;

  out_word_t     expected_words[$];
  logic [31:0]   size_limit;
  stream_phase_e phase;
  logic [2:0]    hdr_idx;
  logic [31:0]   stream_size;
  logic [31:0]   owed;
  logic [7:0]    lit_left;
  logic [7:0]    run_len;
  logic [2:0]    fault;

  task automatic clear_stream();
    phase       = S_HEADER;
    hdr_idx     = '0;
    stream_size = '0;
    owed        = '0;
    lit_left    = '0;
    run_len     = '0;
    fault       = ST_OK;
  endtask

  task automatic push_word(input logic [DATA_W-1:0] data, input logic [COUNT_W-1:0] count,
                           input logic closing, input logic [2:0] status);
    out_word_t w;
    w.data    = data;
    w.count   = count;
    w.closing = closing;
    w.status  = status;
    expected_words.push_back(w);
  endtask

  // A repeat run is packed into full words, with the remainder in a short final word.
  task automatic push_fill(input logic [7:0] value, input int unsigned n);
    int unsigned       take;
    int unsigned       i;
    logic [DATA_W-1:0] word;
    while (n > 0) begin
      take = (n < OUT_BYTES) ? n : OUT_BYTES;
      word = '0;
      for (i = 0; i < take; i++) begin
        word[8*i +: 8] = value;
      end
      push_word(word, COUNT_W'(take), 1'b0, ST_OK);
      n -= take;
    end
  endtask

  task automatic close_header();
    if (stream_size == 0) begin
      phase = S_DONE;
    end else if (stream_size > size_limit) begin
      fault = ST_TOO_LARGE;
      phase = S_FAULT;
    end else begin
      owed  = stream_size;
      phase = S_FLAG;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic is_last);
    int unsigned n;
    logic [2:0]  st;
    case (phase)
      S_HEADER: begin
        if (hdr_idx >= 1 && hdr_idx <= 3) begin
          stream_size |= 32'(b) << (8 * (hdr_idx - 1));
        end else if (hdr_idx >= 4) begin
          stream_size |= 32'(b) << (8 * (hdr_idx - 4));
        end
        if (hdr_idx == 3) begin
          if (stream_size == 0) begin
            hdr_idx = 3'd4;
          end else begin
            close_header();
          end
        end else if (hdr_idx == 7) begin
          close_header();
        end else begin
          hdr_idx = hdr_idx + 3'd1;
        end
      end
      S_FLAG: begin
        if (b[7]) begin
          run_len = {1'b0, b[6:0]} + 8'd3;
          phase   = S_VALUE;
        end else begin
          lit_left = b + 8'd1;
          phase    = S_LITERAL;
        end
      end
      S_VALUE: begin
        n = (run_len < owed) ? run_len : owed;
        push_fill(b, n);
        owed    = owed - n;
        run_len = '0;
        phase   = (owed == 0) ? S_DONE : S_FLAG;
      end
      S_LITERAL: begin
        if (owed > 0) begin
          push_word(DATA_W'(b), COUNT_W'(1), 1'b0, ST_OK);
          owed = owed - 1;
        end
        if (lit_left > 0) begin
          lit_left = lit_left - 8'd1;
        end
        if (lit_left == 0) begin
          phase = (owed == 0) ? S_DONE : S_FLAG;
        end
      end
      default: begin
      end
    endcase
    if (is_last) begin
      case (phase)
        S_HEADER:         st = (hdr_idx <= 3) ? ST_HDR_SHORT : ST_EXT_SHORT;
        S_FLAG, S_VALUE:  st = ST_TRUNC;
        S_LITERAL:        st = ST_LIT_TRUNC;
        S_FAULT:          st = fault;
        default:          st = ST_OK;
      endcase
      push_word('0, '0, 1'b1, st);
      clear_stream();
    end
  endtask

  task automatic check_word();
    out_word_t want;
    out_word_t got;
    got = {out_data_i, out_count_i, out_end_i, out_status_i};
    if (expected_words.size() == 0) begin
      error_count_o++;
      if (error_count_o <= MAX_SHOWN) begin
        $display("%0t: unexpected result data=%h count=%0d end=%0b status=%0d", $time,
                 got.data, got.count, got.closing, got.status);
      end
    end else begin
      want = expected_words.pop_front();
      if (got !== want) begin
        error_count_o++;
        if (error_count_o <= MAX_SHOWN) begin
          $display("%0t: result mismatch, expected data=%h count=%0d end=%0b status=%0d",
                   $time, want.data, want.count, want.closing, want.status);
          $display("%0t:                   actual data=%h count=%0d end=%0b status=%0d",
                   $time, got.data, got.count, got.closing, got.status);
        end
      end
    end
  endtask

  // Results are compared before the input transaction of the same edge is decoded,
  // since no result can come out in the cycle its byte goes in.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_limit = MAX_SIZE_RESET;
      clear_stream();
      expected_words.delete();
      error_count_o = 0;
      pending_o     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        size_limit = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        check_word();
      end
      if (in_valid_i && !in_stall_i) begin
        decode_byte(in_byte_i, in_last_i);
      end
      pending_o = expected_words.size();
    end
  end

endmodule

// ----- bench/rle_byte_stream_decompressor_test.sv -----
`timescale 1ns / 100ps

module rle_byte_stream_decompressor_test;
  import rbsd_pkg::*;

  localparam int unsigned ClkPeriod    = 10;
  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned PhaseItems   = 24;
  localparam int unsigned NumPhases    = 5;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_data;
  logic [2:0]  out_count;
  logic        out_end;
  logic [2:0]  out_status;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycle_count;
  int unsigned sent_items;
  logic [7:0]  stream_q[$];
  bit          idle_allowed = 1'b1;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;

  always #(ClkPeriod / 2) clk = ~clk;

  rle_byte_stream_decompressor DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_byte_i    (in_byte),
    .in_last_i    (in_last),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_o   (out_data),
    .out_count_o  (out_count),
    .out_end_o    (out_end),
    .out_status_o (out_status)
  );

  rbsd_stream_checker stream_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_byte_i     (in_byte),
    .in_last_i     (in_last),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .out_count_i   (out_count),
    .out_end_i     (out_end),
    .out_status_i  (out_status),
    .error_count_o (mismatches),
    .pending_o     (pending)
  );

  // The receiver stalls in short random bursts, or for one long stretch on request.
  initial begin
    int unsigned burst;
    int unsigned hold;
    burst     = 0;
    hold      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold     = HoldCycles;
      end else if (hold > 0) begin
        hold--;
      end
      if (burst > 0) begin
        burst--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 11);
      end
      out_stall = (hold > 0) || (burst > 0);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap      = $urandom_range(1, 11);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    in_last  = is_last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_stream();
    int unsigned i;
    for (i = 0; i < stream_q.size(); i++) begin
      send_byte(stream_q[i], i == stream_q.size() - 1);
    end
    stream_q.delete();
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_header(input logic [31:0] size, input bit ext);
    stream_q.push_back(8'($urandom_range(0, 255)));
    if (ext) begin
      repeat (3) stream_q.push_back(8'h00);
      stream_q.push_back(size[7:0]);
      stream_q.push_back(size[15:8]);
      stream_q.push_back(size[23:16]);
      stream_q.push_back(size[31:24]);
    end else begin
      stream_q.push_back(size[7:0]);
      stream_q.push_back(size[15:8]);
      stream_q.push_back(size[23:16]);
    end
  endtask

  // Huge sizes get only a few runs, so those streams end truncated.
  task automatic add_body(input logic [31:0] size);
    logic [31:0] left;
    int unsigned len;
    int unsigned runs;
    left = size;
    runs = (size > 400) ? 3 : 32'hFFFF_FFFF;
    while (left > 0 && runs > 0) begin
      if ($urandom_range(0, 1) == 1) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 130) : $urandom_range(3, 12);
        stream_q.push_back(8'h80 | 8'(len - 3));
        stream_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
        stream_q.push_back(8'(len - 1));
        repeat (len) stream_q.push_back(8'($urandom_range(0, 255)));
      end
      left = (len < left) ? left - len : 0;
      runs--;
    end
  endtask

  task automatic random_stream();
    int unsigned kind;
    int unsigned pick;
    int unsigned cut;
    logic [31:0] size;
    bit          ext;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 10)) stream_q.push_back(8'($urandom_range(0, 255)));
      sent_items += stream_q.size();
    end else begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        size = 0;
      end else if (pick == 1) begin
        size = $urandom;
      end else if (pick == 2) begin
        size = $urandom_range(60, 200);
      end else begin
        size = $urandom_range(1, 24);
      end
      ext = (size > 32'hFF_FFFF) || (size[23:0] == 0) || ($urandom_range(0, 5) == 0);
      add_header(size, ext);
      add_body(size);
      if (kind >= 7) begin
        cut = $urandom_range(1, stream_q.size());
        while (stream_q.size() > cut) stream_q.delete(stream_q.size() - 1);
        sent_items += stream_q.size();
      end else begin
        repeat ($urandom_range(0, 2)) stream_q.push_back(8'($urandom_range(0, 255)));
        sent_items += stream_q.size();
      end
    end
    idle_on = idle_allowed && ($urandom_range(0, 3) != 0);
    send_stream();
  endtask

  initial begin
    logic [31:0] limits[NumPhases];
    int unsigned p;
    int unsigned start;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_byte   = '0;
    in_last   = 1'b0;
    sent_items = 0;
    limits[0] = 32'h0;
    limits[1] = 32'hFFFF_FFFF;
    limits[2] = $urandom_range(8, 40);
    limits[3] = MAX_SIZE_RESET;
    limits[4] = $urandom;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty size through the extended header.
    stream_q = '{8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_stream();
    // Longest repeat, sent while the receiver holds off so the block backs up.
    hold_req = 1'b1;
    stream_q = '{8'h30, 8'h82, 8'h00, 8'h00, 8'hFF, 8'h55};
    send_stream();
    // Literal run clamped to the size and then cut short.
    stream_q = '{8'h30, 8'h01, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00};
    send_stream();
    // Header cut after its first byte.
    stream_q = '{8'hFF};
    send_stream();
    // Repeat flag with no value byte.
    stream_q = '{8'h30, 8'h05, 8'h00, 8'h00, 8'h80};
    send_stream();

    for (p = 0; p < NumPhases; p++) begin
      drain();
      write_limit(limits[p]);
      idle_allowed = (p != NumPhases - 1);
      idle_on      = idle_allowed;
      start        = sent_items;
      while (sent_items - start < PhaseItems) random_stream();
    end
    drain();

    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rbsd_pkg.sv
rtl/rbsd_ctrl.sv
rtl/rbsd_datapath.sv
rtl/rle_byte_stream_decompressor.sv
bench/rbsd_stream_checker.sv
bench/rle_byte_stream_decompressor_test.sv
